@@ rtl/core/pion_nucleon_xsec_log_table_interp_macros.svh @@
// assertion macros for the pion-nucleon cross-section block
// expects clk and arst_n in the scope of each use
`ifndef PION_NUCLEON_XSEC_LOG_TABLE_INTERP_MACROS_SVH
`define PION_NUCLEON_XSEC_LOG_TABLE_INTERP_MACROS_SVH

// same-cycle implication
`define PNX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PNX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/pnx_pkg.sv @@
// shared types, tables and constants for the pion-nucleon cross-section block
// no dependencies
`default_nettype none

package pnx_pkg;

	localparam int unsigned ENERGY_FRAC_BITS_DEF = 16;
	localparam int unsigned LOG_FRAC = 20;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned LOG_STEPS = LOG_FRAC;
	localparam int unsigned NUM_BINS = 60;
	localparam int unsigned ADDR_W = 3;

	localparam logic [31:0] MASS_SQ_RESET = 32'd83665600;
	localparam logic REG_MASS_SQ = 1'b0;

	localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
	localparam logic signed [31:0] U_OFFSET_Q20 = 32'sd20447232;
	localparam logic [11:0] LAST_BIN = 12'd58;
	localparam logic [5:0] TOP_IDX = 6'd59;
	localparam logic [22:0] OUT_MAX = 23'd8388607;
	localparam logic [20:0] RAMP_K_INEL = 21'd987681;
	localparam logic [20:0] RAMP_K_TOTAL = 21'd2012494;
	// rounding of thousandths*2^20 to Q16: (v + 8000) / 16000, split as >>7 then /125
	localparam logic [12:0] ROUND_HALF = 13'd8000;
	localparam logic [31:0] RECIP_125 = 32'd2199023256;
	localparam int unsigned RECIP_SHIFT = 38;

	typedef struct packed {
		logic command;
		logic [31:0] energy_q16;
	} req_t;

	typedef struct packed {
		logic [22:0] cross_section_q16;
		logic below_threshold;
	} rsp_t;

	// one step of the square root row
	typedef struct packed {
		logic sel;
		logic [63:0] rad;
		logic [63:0] root;
	} sqrt_t;

	// normalise and log rows
	typedef struct packed {
		logic sel;
		logic [31:0] p;
		logic [4:0] k;
		logic [31:0] m;
		logic [19:0] frac;
	} cell_t;

	localparam logic [16:0] TAB_INEL [NUM_BINS] = '{
		17'd1596, 17'd3192, 17'd5692, 17'd5596, 17'd3788, 17'd6528,
		17'd22931, 17'd43462, 17'd55580, 17'd36761, 17'd19754, 17'd12588,
		17'd12914, 17'd12500, 17'd13707, 17'd15082, 17'd19671, 17'd16860,
		17'd21708, 17'd29128, 17'd21752, 17'd22444, 17'd23698, 17'd23847,
		17'd23067, 17'd25336, 17'd25366, 17'd25273, 17'd24646, 17'd24003,
		17'd23636, 17'd23615, 17'd23029, 17'd22667, 17'd22434, 17'd21901,
		17'd21763, 17'd22235, 17'd20177, 17'd21707, 17'd20827, 17'd21102,
		17'd21028, 17'd21155, 17'd20932, 17'd20577, 17'd20865, 17'd21122,
		17'd21193, 17'd21081, 17'd20611, 17'd20788, 17'd20591, 17'd20514,
		17'd20796, 17'd20813, 17'd20425, 17'd20460, 17'd20495, 17'd20530
	};

	localparam logic [16:0] TAB_TOTAL [NUM_BINS] = '{
		17'd3252, 17'd6504, 17'd12316, 17'd18314, 17'd22600, 17'd31435,
		17'd53933, 17'd84872, 17'd102626, 17'd87084, 17'd60234, 17'd39922,
		17'd32804, 17'd28935, 17'd27952, 17'd29439, 17'd36824, 17'd31814,
		17'd35152, 17'd50062, 17'd39079, 17'd35741, 17'd37390, 17'd35575,
		17'd34043, 17'd34363, 17'd34171, 17'd32990, 17'd32110, 17'd31316,
		17'd30621, 17'd29918, 17'd29134, 17'd28461, 17'd27985, 17'd27208,
		17'd26749, 17'd27111, 17'd25047, 17'd26357, 17'd25393, 17'd25777,
		17'd25467, 17'd25305, 17'd25008, 17'd24814, 17'd24662, 17'd24481,
		17'd24453, 17'd24336, 17'd24099, 17'd24098, 17'd24010, 17'd23908,
		17'd23992, 17'd24058, 17'd23805, 17'd23808, 17'd23811, 17'd23815
	};

	function automatic logic [16:0] tab_value(input logic sel, input logic [5:0] idx);
		logic [16:0] val;
		val = 17'd0;
		if (idx <= TOP_IDX) begin
			val = sel ? TAB_TOTAL[idx] : TAB_INEL[idx];
		end
		return val;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/pnx_sqrt_cell.sv @@
// one restoring step of the 64-bit integer square root row
// depends on pnx_pkg
`default_nettype none

module pnx_sqrt_cell
	import pnx_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire sqrt_t in_data,
	output logic out_valid,
	output sqrt_t out_data
);

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

	logic [63:0] trial;
	sqrt_t nxt;

	always_comb begin
		trial = in_data.root + BIT;
		nxt = in_data;
		if (in_data.rad >= trial) begin
			nxt.rad = in_data.rad - trial;
			nxt.root = (in_data.root >> 1) + BIT;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pnx_norm_cell.sv @@
// one stage of the leading-one normaliser: shift left when the top bits are clear
// depends on pnx_pkg
`default_nettype none

module pnx_norm_cell
	import pnx_pkg::*;
#(
	parameter int unsigned SHIFT = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire cell_t in_data,
	output logic out_valid,
	output cell_t out_data
);

	cell_t nxt;

	always_comb begin
		nxt = in_data;
		if (in_data.m[31:32-SHIFT] == '0) begin
			nxt.m = in_data.m << SHIFT;
			nxt.k = in_data.k - 5'(SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pnx_log_cell.sv @@
// one squaring step of the log2 fraction: square the mantissa, take one bit
// depends on pnx_pkg
`default_nettype none

module pnx_log_cell
	import pnx_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire cell_t in_data,
	output logic out_valid,
	output cell_t out_data
);

	logic [63:0] sq;
	logic [32:0] sh;
	cell_t nxt;

	always_comb begin
		sq = 64'(in_data.m) * 64'(in_data.m);
		sh = sq[63:31];
		nxt = in_data;
		if (sh[32]) begin
			nxt.frac = {in_data.frac[18:0], 1'b1};
			nxt.m = sh[32:1];
		end else begin
			nxt.frac = {in_data.frac[18:0], 1'b0};
			nxt.m = sh[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pnx_interp.sv @@
// tail of the pipe: log10, bin select, ramp, interpolation and rounding
// depends on pnx_pkg
`default_nettype none

module pnx_interp
	import pnx_pkg::*;
#(
	parameter int unsigned ENERGY_FRAC_BITS = ENERGY_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire cell_t in_data,
	output logic out_valid,
	output rsp_t out_data
);

	logic [7:1] vld_q;

	// stage 1: log2 to log10 product
	logic signed [6:0] kf;
	logic signed [26:0] l2;
	logic signed [59:0] prod_s1;
	logic zero_s1, sel_s1;
	logic [31:0] p_s1;

	// stage 2: bin coordinate
	logic signed [27:0] lg;
	logic signed [31:0] lg_ext, u;
	logic signed [31:0] u_s2;
	logic zero_s2, sel_s2;
	logic [31:0] p_s2;

	// stage 3: lookup and ramp product
	logic [11:0] n;
	logic hi;
	logic [5:0] idx0, idx1;
	logic [16:0] base, nxt_val;
	logic [52:0] ramp_s3;
	logic [16:0] base_s3;
	logic signed [17:0] diff_s3;
	logic [19:0] f_s3;
	logic zero_s3, neg_s3;

	// stage 4: slope product and ramp shift
	logic [52:0] ramp_sh;
	logic signed [38:0] fd_s4;
	logic [16:0] base_s4;
	logic [22:0] ramp_s4;
	logic zero_s4, neg_s4;

	// stage 5: sum and first rounding shift
	logic signed [39:0] v, vr;
	logic [30:0] w_s5;
	logic [22:0] ramp_s5;
	logic zero_s5, neg_s5;

	// stage 6: reciprocal multiply for /125
	logic [62:0] q_s6;
	logic [22:0] ramp_s6;
	logic zero_s6, neg_s6;

	// stage 7: result
	logic [24:0] r;
	rsp_t res;

	always_comb begin
		kf = $signed({2'b00, in_data.k}) - $signed(7'(ENERGY_FRAC_BITS));
		l2 = $signed({kf, 20'b0}) + $signed({7'b0, in_data.frac});
	end

	always_comb begin
		lg = prod_s1[59:32];
		lg_ext = 32'(lg);
		u = (lg_ext <<< 4) + (lg_ext <<< 2) + U_OFFSET_Q20;
	end

	always_comb begin
		n = u_s2[31:20];
		hi = (n > LAST_BIN);
		idx0 = hi ? TOP_IDX : n[5:0];
		idx1 = hi ? TOP_IDX : n[5:0] + 6'd1;
		base = tab_value(sel_s2, idx0);
		nxt_val = tab_value(sel_s2, idx1);
	end

	always_comb begin
		ramp_sh = ramp_s3 >> ENERGY_FRAC_BITS;
		v = $signed({3'b000, base_s4, 20'b0}) + 40'(fd_s4);
		vr = v[39] ? 40'sd0 : v;
	end

	always_comb begin
		r = q_s6[62:RECIP_SHIFT];
		res.below_threshold = zero_s6;
		if (zero_s6) begin
			res.cross_section_q16 = '0;
		end else if (neg_s6) begin
			res.cross_section_q16 = ramp_s6;
		end else if (r > 25'(OUT_MAX)) begin
			res.cross_section_q16 = OUT_MAX;
		end else begin
			res.cross_section_q16 = r[22:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 60'(l2) * $signed({28'b0, LOG10_2_Q32});
			zero_s1 <= (in_data.p == '0);
			sel_s1 <= in_data.sel;
			p_s1 <= in_data.p;

			u_s2 <= u;
			zero_s2 <= zero_s1;
			sel_s2 <= sel_s1;
			p_s2 <= p_s1;

			ramp_s3 <= 53'(p_s2) * 53'(sel_s2 ? RAMP_K_TOTAL : RAMP_K_INEL);
			base_s3 <= base;
			diff_s3 <= $signed({1'b0, nxt_val}) - $signed({1'b0, base});
			f_s3 <= hi ? 20'd0 : u_s2[19:0];
			zero_s3 <= zero_s2;
			neg_s3 <= u_s2[31];

			fd_s4 <= $signed({19'b0, f_s3}) * 39'(diff_s3);
			base_s4 <= base_s3;
			ramp_s4 <= (ramp_sh > 53'(OUT_MAX)) ? OUT_MAX : ramp_sh[22:0];
			zero_s4 <= zero_s3;
			neg_s4 <= neg_s3;

			w_s5 <= 31'((vr + 40'(ROUND_HALF)) >>> 7);
			ramp_s5 <= ramp_s4;
			zero_s5 <= zero_s4;
			neg_s5 <= neg_s4;

			q_s6 <= 63'(w_s5) * 63'(RECIP_125);
			ramp_s6 <= ramp_s5;
			zero_s6 <= zero_s5;
			neg_s6 <= neg_s5;

			out_data <= res;
		end
	end

	assign out_valid = vld_q[7];

endmodule

`default_nettype wire

@@ rtl/core/pion_nucleon_xsec_log_table_interp.sv @@
// Pion-nucleon cross-section lookup: one request per cycle, fully pipelined. Each request
// carries a pion energy and a table select; the block forms the momentum as the integer
// square root of E^2 - m^2, takes log10 of it by repeated squaring, picks one of 60
// log-spaced bins and interpolates, or applies the low-momentum ramp or the top-bin
// saturation. A new request is taken every cycle while the skid stage is empty; each request
// passes through 3 front stages for the square and the radicand, a row of 32 square-root
// cells, 5 normaliser cells, 20 log cells, 7 tail stages and the output register. The whole
// row moves on together and stops only when the output register and its skid stage are
// both full. pion_mass_sq sits at byte address 0 of the APB port and should only be written
// while no request is in flight.
// depends on pnx_pkg, the cell modules, pnx_interp and the macros header
`default_nettype none
`include "pion_nucleon_xsec_log_table_interp_macros.svh"

module pion_nucleon_xsec_log_table_interp
	import pnx_pkg::*;
#(
	parameter int unsigned ENERGY_FRAC_BITS = ENERGY_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// request channel
	input wire logic req_valid,
	output logic req_ready,
	input wire req_t req_data,
	// result channel
	output logic rsp_valid,
	input wire logic rsp_ready,
	output rsp_t rsp_data,
	// configuration port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	// m^2 is aligned to 2F fraction bits: left for F >= 16, right (dropping bits) below
	localparam int unsigned M2_LSH = (2 * ENERGY_FRAC_BITS >= 32) ? 2 * ENERGY_FRAC_BITS - 32 : 0;
	localparam int unsigned M2_RSH = (2 * ENERGY_FRAC_BITS < 32) ? 32 - 2 * ENERGY_FRAC_BITS : 0;

	logic [31:0] mass_sq_q;
	logic [63:0] m2;
	logic cfg_wr;
	logic reg_idx;

	// whole-pipe advance, held back only by a full skid stage
	logic en;

	// front stages
	logic vld_s1, vld_s2, vld_s3;
	logic [31:0] e_s1;
	logic [63:0] e2_s2, rad_s3;
	logic sel_s1, sel_s2, sel_s3;

	// cell rows
	logic sq_vld [SQRT_STEPS+1];
	sqrt_t sq_dat [SQRT_STEPS+1];
	logic nm_vld [6];
	cell_t nm_dat [6];
	logic lg_vld [LOG_STEPS+1];
	cell_t lg_dat [LOG_STEPS+1];

	// tail result
	logic tail_valid;
	rsp_t tail_data;

	// output register and skid
	logic rsp_valid_q, skid_valid_q;
	rsp_t rsp_q, skid_q;
	logic take, push;

	// configuration
	assign reg_idx = paddr[ADDR_W-1];
	assign cfg_wr = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (reg_idx)
			REG_MASS_SQ: prdata = mass_sq_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_sq_q <= MASS_SQ_RESET;
		end else if (cfg_wr && reg_idx == REG_MASS_SQ) begin
			mass_sq_q <= pwdata;
		end
	end

	assign m2 = ({32'b0, mass_sq_q} << M2_LSH) >> M2_RSH;

	// front: capture, square, radicand clipped at zero
	assign en = !skid_valid_q;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= req_data.energy_q16;
			sel_s1 <= req_data.command;
			e2_s2 <= 64'(e_s1) * 64'(e_s1);
			sel_s2 <= sel_s1;
			rad_s3 <= (e2_s2 > m2) ? e2_s2 - m2 : 64'd0;
			sel_s3 <= sel_s2;
		end
	end

	// square root row, two radicand bits per cell
	assign sq_vld[0] = vld_s3;
	assign sq_dat[0] = '{sel: sel_s3, rad: rad_s3, root: 64'd0};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		pnx_sqrt_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(sq_vld[i]),
			.in_data(sq_dat[i]),
			.out_valid(sq_vld[i+1]),
			.out_data(sq_dat[i+1])
		);
	end

	// normaliser row: shifts of 16, 8, 4, 2, 1 put the leading one at bit 31
	assign nm_vld[0] = sq_vld[SQRT_STEPS];
	assign nm_dat[0] = '{
		sel: sq_dat[SQRT_STEPS].sel,
		p: sq_dat[SQRT_STEPS].root[31:0],
		k: 5'd31,
		m: sq_dat[SQRT_STEPS].root[31:0],
		frac: 20'd0
	};

	for (genvar j = 0; j < 5; j++) begin : g_norm
		pnx_norm_cell #(.SHIFT(16 >> j)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(nm_vld[j]),
			.in_data(nm_dat[j]),
			.out_valid(nm_vld[j+1]),
			.out_data(nm_dat[j+1])
		);
	end

	// log row, one fraction bit per cell
	assign lg_vld[0] = nm_vld[5];
	assign lg_dat[0] = nm_dat[5];

	for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
		pnx_log_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(lg_vld[g]),
			.in_data(lg_dat[g]),
			.out_valid(lg_vld[g+1]),
			.out_data(lg_dat[g+1])
		);
	end

	pnx_interp #(.ENERGY_FRAC_BITS(ENERGY_FRAC_BITS)) u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(lg_vld[LOG_STEPS]),
		.in_data(lg_dat[LOG_STEPS]),
		.out_valid(tail_valid),
		.out_data(tail_data)
	);

	// output register with one skid entry behind it
	assign take = rsp_valid_q & rsp_ready;
	assign push = en & tail_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid_q || take) begin
			if (skid_valid_q) begin
				rsp_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid_q || take) begin
			rsp_q <= skid_valid_q ? skid_q : tail_data;
		end else if (push) begin
			skid_q <= tail_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

	// skid is only ever occupied behind a waiting result
	`PNX_ASSERT_NOW(a_skid_behind_out, skid_valid_q, rsp_valid_q, "skid full with empty output")
	// skid fills only when the output was stalled
	`PNX_ASSERT_NOW(a_skid_fill, $rose(skid_valid_q), $past(rsp_valid_q && !rsp_ready),
		"skid filled without a stall")
	// a below-threshold result carries zero cross section
	`PNX_ASSERT_NOW(a_zero_below, rsp_valid && rsp_data.below_threshold,
		rsp_data.cross_section_q16 == '0, "below threshold with non-zero result")

endmodule

`default_nettype wire

@@ tb/pion_nucleon_xsec_log_table_interp_checker.sv @@
// checker for the pion-nucleon cross-section block: mirrors the mass register,
// predicts each result from the request stream and compares in order
// depends on pnx_pkg
`default_nettype none

module pion_nucleon_xsec_log_table_interp_checker
	import pnx_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req_data,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] mass_sq;
	rsp_t xsec_queue[$];

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bit_w;
		root = 64'd0;
		bit_w = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= root + bit_w) begin
				v = v - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root;
	endfunction

	// log10 of p / 2^16 with 20 fraction bits, floored
	function automatic longint log10_q20(input logic [31:0] p);
		int k;
		logic [63:0] m;
		logic [63:0] frac;
		longint l2;
		logic [63:0] mag;
		k = 31;
		frac = 64'd0;
		while (k > 0 && !p[k]) k--;
		m = {32'd0, p} << (31 - k);
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		l2 = longint'(k - 16) * (longint'(1) << LOG_FRAC) + longint'(frac);
		if (l2 >= 0)
			return longint'((64'(l2) * 64'(LOG10_2_Q32)) >> 32);
		mag = 64'(-l2);
		return -longint'((mag * 64'(LOG10_2_Q32) + 64'hFFFF_FFFF) >> 32);
	endfunction

	function automatic rsp_t xsec_predict(input req_t r, input logic [31:0] msq);
		rsp_t o;
		logic [63:0] e2;
		logic [63:0] p;
		logic [63:0] res;
		longint u;
		longint base;
		longint diff;
		longint f;
		longint v;
		logic [63:0] n;
		e2 = 64'(r.energy_q16) * 64'(r.energy_q16);
		p = (e2 > 64'(msq)) ? root_floor(e2 - 64'(msq)) : 64'd0;
		o.below_threshold = 1'b0;
		if (p == 0) begin
			o.cross_section_q16 = 23'd0;
			o.below_threshold = 1'b1;
			return o;
		end
		u = 20 * log10_q20(p[31:0]) + longint'(U_OFFSET_Q20);
		if (u < 0) begin
			res = (p * 64'(r.command ? RAMP_K_TOTAL : RAMP_K_INEL)) >> 16;
		end else begin
			n = 64'(u) >> LOG_FRAC;
			if (n > 58) begin
				base = r.command ? TAB_TOTAL[59] : TAB_INEL[59];
				res = ((64'(base) << LOG_FRAC) + 64'd8000) / 64'd16000;
			end else begin
				f = u & ((longint'(1) << LOG_FRAC) - 1);
				base = r.command ? TAB_TOTAL[n] : TAB_INEL[n];
				diff = longint'(r.command ? TAB_TOTAL[n + 1] : TAB_INEL[n + 1]) - base;
				v = base * (longint'(1) << LOG_FRAC) + f * diff;
				if (v < 0) v = 0;
				res = (64'(v) + 64'd8000) / 64'd16000;
			end
		end
		if (res > 64'(OUT_MAX)) res = 64'(OUT_MAX);
		o.cross_section_q16 = res[22:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			mass_sq <= MASS_SQ_RESET;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_MASS_SQ)
				mass_sq <= pwdata;
			if (req_valid && req_ready)
				xsec_queue.push_back(xsec_predict(req_data, mass_sq));
			if (rsp_valid && rsp_ready) begin
				if (xsec_queue.size() == 0) begin
					$error("unexpected result %h", rsp_data);
					errs++;
				end else begin
					want = xsec_queue.pop_front();
					if (want.cross_section_q16 !== rsp_data.cross_section_q16) begin
						$error("cross_section_q16: expected %0d, got %0d",
							want.cross_section_q16, rsp_data.cross_section_q16);
						errs++;
					end
					if (want.below_threshold !== rsp_data.below_threshold) begin
						$error("below_threshold: expected %0d, got %0d",
							want.below_threshold, rsp_data.below_threshold);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= xsec_queue.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/pion_nucleon_xsec_log_table_interp_tb.sv @@
// testbench top for the pion-nucleon cross-section block: drives requests, results
// back-pressure and mass register writes; the checker does prediction and comparison
// depends on pnx_pkg, the block and pion_nucleon_xsec_log_table_interp_checker
`default_nettype none

module pion_nucleon_xsec_log_table_interp_tb;
	import pnx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	// when set neither side idles between requests
	logic no_idle = 1'b0;
	int rsp_seen = 0;
	int quiet_cycles = 0;
	logic [31:0] mass_now = MASS_SQ_RESET;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int LONG_HOLD = 400;

	always #5 clk = ~clk;

	pion_nucleon_xsec_log_table_interp dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pion_nucleon_xsec_log_table_interp_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold once the pipe is busy
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 6);
			if (rsp_seen == 400) gap = LONG_HOLD;
			if (gap > 0) begin
				rsp_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready = 1'b1;
			#1;
			while (!rsp_valid) begin
				@(negedge clk);
				#1;
			end
			@(posedge clk);
			rsp_seen++;
			@(negedge clk);
		end
	end

	// one request: optional idle gap, then hold valid and payload until taken
	task automatic send_request(input logic cmd, input logic [31:0] energy);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data.command = cmd;
		req_data.energy_q16 = energy;
		req_valid = 1'b1;
		#1;
		while (!req_ready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		@(negedge clk);
	endtask

	// register writes only with the pipe empty and the latency waited out
	task automatic write_mass(input logic [ADDR_W-1:0] addr, input logic [31:0] val);
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if ((addr >> 2) == REG_MASS_SQ) mass_now = val;
	endtask

	// energy spread: threshold edge, ramp region, bin range, saturation, anything
	function automatic logic [31:0] pick_energy();
		logic [31:0] thr;
		logic [63:0] r;
		int unsigned pick;
		r = 64'd0;
		thr = 32'd0;
		// threshold in Q16 is the root of the Q32 mass
		for (int b = 31; b >= 0; b--) begin
			r = {32'd0, thr | (32'd1 << b)};
			if (r * r <= 64'(mass_now)) thr = thr | (32'd1 << b);
		end
		pick = $urandom_range(0, 9);
		case (pick)
			0: return thr + $urandom_range(0, 40) - 20;
			1, 2: return thr + $urandom_range(0, 16000);
			3, 4, 5: return $urandom_range(0, 32'h0000_FFFF) << $urandom_range(0, 7);
			6: return $urandom_range(32'h0040_0000, 32'h00FF_FFFF);
			7: return $urandom_range(0, 32'h0010_0000);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [31:0] masses [5];
		logic [31:0] directed [12];
		masses = '{32'd0, 32'hFFFF_FFFF, MASS_SQ_RESET, 32'd1, $urandom()};
		// zero, just below and above threshold, ramp, low bins, top bin, saturation, max
		directed = '{32'd0, 32'd9146, 32'd9147, 32'd9200, 32'd11000, 32'd12000,
			32'd20000, 32'd65536, 32'd1000000, 32'd5400000, 32'd40000000, 32'hFFFF_FFFF};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i]) begin
			send_request(1'b0, directed[i]);
			send_request(1'b1, directed[i]);
		end
		// an address other than the mass register must leave it alone
		write_mass(3'd4, 32'h1234_5678);
		foreach (masses[ph]) begin
			write_mass(3'd0, masses[ph]);
			no_idle = (ph % 2) == 1;
			for (int i = 0; i < 305; i++) begin
				if (i == 150) no_idle = ~no_idle;
				send_request(1'($urandom_range(0, 1)), pick_energy());
			end
		end
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/pnx_pkg.sv
rtl/core/pnx_sqrt_cell.sv
rtl/core/pnx_norm_cell.sv
rtl/core/pnx_log_cell.sv
rtl/core/pnx_interp.sv
rtl/core/pion_nucleon_xsec_log_table_interp.sv
tb/pion_nucleon_xsec_log_table_interp_checker.sv
tb/pion_nucleon_xsec_log_table_interp_tb.sv
